/* rtl/md5c_pkg.sv */
package md5c_pkg;

  localparam int unsigned ROUNDS     = 1000;
  localparam int unsigned HASH_CHARS = 22;
  localparam int unsigned ROUND_W    = 10;

  localparam logic [0:0] CFG_SALT_CHARS  = 1'b0;
  localparam logic [0:0] CFG_SALT_LENGTH = 1'b1;

  localparam logic [31:0] IV0 = 32'h67452301;
  localparam logic [31:0] IV1 = 32'hefcdab89;
  localparam logic [31:0] IV2 = 32'h98badcfe;
  localparam logic [31:0] IV3 = 32'h10325476;

  typedef enum logic [2:0] {
    SRC_PW, SRC_SALT, SRC_MAGIC, SRC_DIG_PL, SRC_DIG16, SRC_MIX, SRC_PAD, SRC_OUT
  } src_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_A_PW1, ST_A_SALT, ST_A_PW2, ST_A_FIN,
    ST_B_PW, ST_B_MAGIC, ST_B_SALT, ST_B_DIG, ST_B_MIX, ST_B_FIN,
    ST_R_FIRST, ST_R_SALT, ST_R_PW, ST_R_LAST, ST_R_FIN,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic init;
    logic go;
    src_t src;
  } cmd_t;

  typedef struct packed {
    logic seg_done;
    logic out_done;
  } stat_t;

  function automatic logic [31:0] md5_k(input logic [5:0] i);
    logic [31:0] r;
    unique case (i)
      6'd0: r = 32'hd76aa478;  6'd1: r = 32'he8c7b756;  6'd2: r = 32'h242070db;
      6'd3: r = 32'hc1bdceee;  6'd4: r = 32'hf57c0faf;  6'd5: r = 32'h4787c62a;
      6'd6: r = 32'ha8304613;  6'd7: r = 32'hfd469501;  6'd8: r = 32'h698098d8;
      6'd9: r = 32'h8b44f7af;  6'd10: r = 32'hffff5bb1; 6'd11: r = 32'h895cd7be;
      6'd12: r = 32'h6b901122; 6'd13: r = 32'hfd987193; 6'd14: r = 32'ha679438e;
      6'd15: r = 32'h49b40821; 6'd16: r = 32'hf61e2562; 6'd17: r = 32'hc040b340;
      6'd18: r = 32'h265e5a51; 6'd19: r = 32'he9b6c7aa; 6'd20: r = 32'hd62f105d;
      6'd21: r = 32'h02441453; 6'd22: r = 32'hd8a1e681; 6'd23: r = 32'he7d3fbc8;
      6'd24: r = 32'h21e1cde6; 6'd25: r = 32'hc33707d6; 6'd26: r = 32'hf4d50d87;
      6'd27: r = 32'h455a14ed; 6'd28: r = 32'ha9e3e905; 6'd29: r = 32'hfcefa3f8;
      6'd30: r = 32'h676f02d9; 6'd31: r = 32'h8d2a4c8a; 6'd32: r = 32'hfffa3942;
      6'd33: r = 32'h8771f681; 6'd34: r = 32'h6d9d6122; 6'd35: r = 32'hfde5380c;
      6'd36: r = 32'ha4beea44; 6'd37: r = 32'h4bdecfa9; 6'd38: r = 32'hf6bb4b60;
      6'd39: r = 32'hbebfbc70; 6'd40: r = 32'h289b7ec6; 6'd41: r = 32'heaa127fa;
      6'd42: r = 32'hd4ef3085; 6'd43: r = 32'h04881d05; 6'd44: r = 32'hd9d4d039;
      6'd45: r = 32'he6db99e5; 6'd46: r = 32'h1fa27cf8; 6'd47: r = 32'hc4ac5665;
      6'd48: r = 32'hf4292244; 6'd49: r = 32'h432aff97; 6'd50: r = 32'hab9423a7;
      6'd51: r = 32'hfc93a039; 6'd52: r = 32'h655b59c3; 6'd53: r = 32'h8f0ccc92;
      6'd54: r = 32'hffeff47d; 6'd55: r = 32'h85845dd1; 6'd56: r = 32'h6fa87e4f;
      6'd57: r = 32'hfe2ce6e0; 6'd58: r = 32'ha3014314; 6'd59: r = 32'h4e0811a1;
      6'd60: r = 32'hf7537e82; 6'd61: r = 32'hbd3af235; 6'd62: r = 32'h2ad7d2bb;
      default: r = 32'heb86d391;
    endcase
    return r;
  endfunction

  function automatic logic [4:0] md5_s(input logic [3:0] i);
    logic [4:0] r;
    unique case (i)
      4'd0: r = 5'd7;   4'd1: r = 5'd12;  4'd2: r = 5'd17;  4'd3: r = 5'd22;
      4'd4: r = 5'd5;   4'd5: r = 5'd9;   4'd6: r = 5'd14;  4'd7: r = 5'd20;
      4'd8: r = 5'd4;   4'd9: r = 5'd11;  4'd10: r = 5'd16; 4'd11: r = 5'd23;
      4'd12: r = 5'd6;  4'd13: r = 5'd10; 4'd14: r = 5'd15; default: r = 5'd21;
    endcase
    return r;
  endfunction

  function automatic logic [3:0] out_order(input logic [3:0] i);
    logic [3:0] r;
    unique case (i)
      4'd0: r = 4'd0;   4'd1: r = 4'd6;   4'd2: r = 4'd12;  4'd3: r = 4'd1;
      4'd4: r = 4'd7;   4'd5: r = 4'd13;  4'd6: r = 4'd2;   4'd7: r = 4'd8;
      4'd8: r = 4'd14;  4'd9: r = 4'd3;   4'd10: r = 4'd9;  4'd11: r = 4'd15;
      4'd12: r = 4'd4;  4'd13: r = 4'd10; 4'd14: r = 4'd5;  default: r = 4'd11;
    endcase
    return r;
  endfunction

  function automatic logic [7:0] b64_char(input logic [5:0] x);
    logic [7:0] r;
    if (x < 6'd2) begin
      r = 8'd46 + {2'b0, x};
    end else if (x < 6'd12) begin
      r = 8'd46 + {2'b0, x};
    end else if (x < 6'd38) begin
      r = 8'd53 + {2'b0, x};
    end else begin
      r = 8'd59 + {2'b0, x};
    end
    return r;
  endfunction

  function automatic logic [7:0] bit_len(input logic [7:0] v);
    logic [7:0] r;
    r = 8'd0;
    for (int k = 0; k < 8; k++) begin
      if (v[k]) begin
        r = 8'(k + 1);
      end
    end
    return r;
  endfunction

endpackage

/* rtl/md5c_ctrl.sv */
module md5c_ctrl
  import md5c_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  start,
  input  logic  pw_last,
  input  stat_t stat,
  output logic  busy,
  output cmd_t  cmd
);

  state_t state, state_next;
  logic fresh;
  logic [ROUND_W-1:0] r;
  logic [1:0] m3;
  logic [2:0] m7;
  logic launch;
  logic last_round;

  assign launch = (state == ST_IDLE) && start && pw_last;
  assign last_round = (r == ROUND_W'(ROUNDS - 1));

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:    if (launch) state_next = ST_A_PW1;
      ST_A_PW1:   if (stat.seg_done) state_next = ST_A_SALT;
      ST_A_SALT:  if (stat.seg_done) state_next = ST_A_PW2;
      ST_A_PW2:   if (stat.seg_done) state_next = ST_A_FIN;
      ST_A_FIN:   if (stat.seg_done) state_next = ST_B_PW;
      ST_B_PW:    if (stat.seg_done) state_next = ST_B_MAGIC;
      ST_B_MAGIC: if (stat.seg_done) state_next = ST_B_SALT;
      ST_B_SALT:  if (stat.seg_done) state_next = ST_B_DIG;
      ST_B_DIG:   if (stat.seg_done) state_next = ST_B_MIX;
      ST_B_MIX:   if (stat.seg_done) state_next = ST_B_FIN;
      ST_B_FIN:   if (stat.seg_done) state_next = ST_R_FIRST;
      ST_R_FIRST: begin
        if (stat.seg_done) begin
          if (m3 != 2'd0) state_next = ST_R_SALT;
          else if (m7 != 3'd0) state_next = ST_R_PW;
          else state_next = ST_R_LAST;
        end
      end
      ST_R_SALT: begin
        if (stat.seg_done) state_next = (m7 != 3'd0) ? ST_R_PW : ST_R_LAST;
      end
      ST_R_PW:    if (stat.seg_done) state_next = ST_R_LAST;
      ST_R_LAST:  if (stat.seg_done) state_next = ST_R_FIN;
      ST_R_FIN:   if (stat.seg_done) state_next = last_round ? ST_OUT : ST_R_FIRST;
      ST_OUT:     if (stat.out_done) state_next = ST_IDLE;
      default:    state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    busy = (state != ST_IDLE);
    cmd.init = launch;
    cmd.go = fresh && (state != ST_IDLE);
    unique case (state)
      ST_A_SALT, ST_B_SALT, ST_R_SALT: cmd.src = SRC_SALT;
      ST_B_MAGIC:                      cmd.src = SRC_MAGIC;
      ST_B_DIG:                        cmd.src = SRC_DIG_PL;
      ST_B_MIX:                        cmd.src = SRC_MIX;
      ST_A_FIN, ST_B_FIN, ST_R_FIN:    cmd.src = SRC_PAD;
      ST_R_FIRST:                      cmd.src = r[0] ? SRC_PW : SRC_DIG16;
      ST_R_LAST:                       cmd.src = r[0] ? SRC_DIG16 : SRC_PW;
      ST_OUT:                          cmd.src = SRC_OUT;
      default:                         cmd.src = SRC_PW;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      fresh <= 1'b0;
      r <= '0;
      m3 <= '0;
      m7 <= '0;
    end else begin
      state <= state_next;
      fresh <= (state_next != state);
      if (launch) begin
        r <= '0;
        m3 <= '0;
        m7 <= '0;
      end else if (state == ST_R_FIN && stat.seg_done) begin
        r <= r + 1'b1;
        m3 <= (m3 == 2'd2) ? 2'd0 : m3 + 2'd1;
        m7 <= (m7 == 3'd6) ? 3'd0 : m7 + 3'd1;
      end
    end
  end

endmodule

/* rtl/md5c_dp.sv */
module md5c_dp
  import md5c_pkg::*;
#(
  parameter int MAX_PASSWORD = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        accept,
  input  logic [7:0]  pw_byte,
  input  logic        has_byte,
  input  logic        cfg_we,
  input  logic [0:0]  cfg_index,
  input  logic [63:0] cfg_data,
  input  cmd_t        cmd,
  output stat_t       stat,
  output logic [7:0]  hash_char,
  output logic        char_last,
  output logic        overflow,
  output logic        hash_valid
);

  localparam int AW = (MAX_PASSWORD > 1) ? $clog2(MAX_PASSWORD) : 1;
  localparam int LW = $clog2(MAX_PASSWORD + 1);

  logic [7:0] store [MAX_PASSWORD];
  logic [7:0] mem_q;
  logic [AW-1:0] rd_addr;
  logic [LW-1:0] pw_len;
  logic [7:0] pw_len8;
  logic ovf;
  logic [63:0] salt_chars;
  logic [3:0] salt_length;
  logic [3:0] sl;

  logic running;
  src_t src;
  logic [7:0] seg_len, len_init, j;
  logic s1_valid;
  src_t s1_src;
  logic [7:0] s1_j;
  logic [7:0] pad_base;
  logic [7:0] s1_byte;
  logic [7:0] pad_k;
  logic [10:0] bits;
  logic issue, done;

  logic [511:0] blk;
  logic [7:0] count;
  logic [31:0] h0, h1, h2, h3;
  logic [31:0] a, b, c, d;
  logic [6:0] step;
  logic comp_busy, comp_start;
  logic [31:0] f, w, t, rotv;
  logic [3:0] g;
  logic [63:0] tt;
  logic [127:0] dig;

  logic out_busy;
  logic [4:0] out_n;
  logic [2:0] grp;
  logic [23:0] v24;
  logic [5:0] sextet;
  logic out_end;

  assign sl = (salt_length > 4'd8) ? 4'd8 : salt_length;
  assign out_end = out_busy && (out_n == 5'(HASH_CHARS - 1));
  assign pw_len8 = 8'(pw_len);

  always_ff @(posedge clk) begin
    if (accept && has_byte && (pw_len < LW'(MAX_PASSWORD))) begin
      store[pw_len[AW-1:0]] <= pw_byte;
    end
    mem_q <= store[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pw_len <= '0;
      ovf <= 1'b0;
      salt_chars <= '0;
      salt_length <= '0;
    end else begin
      if (out_end) begin
        pw_len <= '0;
        ovf <= 1'b0;
      end else if (accept && has_byte) begin
        if (pw_len < LW'(MAX_PASSWORD)) pw_len <= pw_len + 1'b1;
        else ovf <= 1'b1;
      end
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_SALT_CHARS:  salt_chars <= cfg_data;
          CFG_SALT_LENGTH: salt_length <= cfg_data[3:0];
          default: ;
        endcase
      end
    end
  end

  always_comb begin
    unique case (cmd.src)
      SRC_PW:     len_init = pw_len8;
      SRC_SALT:   len_init = {4'd0, sl};
      SRC_MAGIC:  len_init = 8'd3;
      SRC_DIG_PL: len_init = pw_len8;
      SRC_DIG16:  len_init = 8'd16;
      SRC_MIX:    len_init = bit_len(pw_len8);
      SRC_PAD:    len_init = {2'b0, 6'd55 - count[5:0]} + 8'd9;
      default:    len_init = 8'd0;
    endcase
  end

  assign issue = running && (j != seg_len) && !comp_busy
                 && !(s1_valid && count[5:0] == 6'd63);
  assign done = running && (j == seg_len) && !s1_valid && !comp_busy;
  assign rd_addr = (src == SRC_MIX) ? '0 : j[AW-1:0];
  assign bits = {pad_base, 3'b0};
  assign pad_k = s1_j - (seg_len - 8'd8);

  always_comb begin
    unique case (s1_src)
      SRC_PW:    s1_byte = mem_q;
      SRC_SALT:  s1_byte = salt_chars[8*s1_j[2:0] +: 8];
      SRC_MAGIC: s1_byte = (s1_j == 8'd1) ? 8'h31 : 8'h24;
      SRC_DIG_PL, SRC_DIG16: s1_byte = dig[8*s1_j[3:0] +: 8];
      SRC_MIX:   s1_byte = pw_len8[s1_j[2:0]] ? 8'h00 : mem_q;
      SRC_PAD: begin
        if (s1_j == 8'd0) s1_byte = 8'h80;
        else if (s1_j >= seg_len - 8'd8) begin
          if (pad_k == 8'd0) s1_byte = bits[7:0];
          else if (pad_k == 8'd1) s1_byte = {5'd0, bits[10:8]};
          else s1_byte = 8'h00;
        end else s1_byte = 8'h00;
      end
      default: s1_byte = 8'h00;
    endcase
  end

  assign comp_start = s1_valid && (count[5:0] == 6'd63);

  always_comb begin
    unique case (step[5:4])
      2'd0: begin f = (b & c) | (~b & d); g = step[3:0]; end
      2'd1: begin f = (d & b) | (~d & c); g = 4'(5 * step[3:0] + 1); end
      2'd2: begin f = b ^ c ^ d;          g = 4'(3 * step[3:0] + 5); end
      default: begin f = c ^ (b | ~d);    g = 4'(7 * step[3:0]); end
    endcase
    w = blk[32*g +: 32];
    t = a + f + md5_k(step[5:0]) + w;
    tt = {t, t} << md5_s({step[5:4], step[1:0]});
    rotv = tt[63:32];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      s1_valid <= 1'b0;
      comp_busy <= 1'b0;
    end else begin
      s1_valid <= issue;
      if (cmd.go && cmd.src != SRC_OUT) running <= 1'b1;
      else if (done) running <= 1'b0;
      if (comp_start) comp_busy <= 1'b1;
      else if (comp_busy && step[6]) comp_busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    s1_src <= src;
    s1_j <= j;
    if (cmd.go && cmd.src != SRC_OUT) begin
      src <= cmd.src;
      seg_len <= len_init;
      j <= 8'd0;
      pad_base <= count;
    end else if (issue) begin
      j <= j + 8'd1;
    end
    if (cmd.init) begin
      h0 <= IV0; h1 <= IV1; h2 <= IV2; h3 <= IV3;
      count <= 8'd0;
    end else if (done && src == SRC_PAD) begin
      dig <= {h3, h2, h1, h0};
      h0 <= IV0; h1 <= IV1; h2 <= IV2; h3 <= IV3;
      count <= 8'd0;
    end else if (comp_busy && step[6]) begin
      h0 <= h0 + a; h1 <= h1 + b; h2 <= h2 + c; h3 <= h3 + d;
    end
    if (s1_valid) begin
      blk[8*count[5:0] +: 8] <= s1_byte;
      count <= count + 8'd1;
    end
    if (comp_start) begin
      a <= h0; b <= h1; c <= h2; d <= h3;
      step <= 7'd0;
    end else if (comp_busy && !step[6]) begin
      a <= d;
      d <= c;
      c <= b;
      b <= b + rotv;
      step <= step + 7'd1;
    end
  end

  assign grp = out_n[4:2];

  always_comb begin
    if (grp < 3'd5) begin
      v24 = {dig[8*out_order(4'(3 * grp)) +: 8],
             dig[8*out_order(4'(3 * grp + 1)) +: 8],
             dig[8*out_order(4'(3 * grp + 2)) +: 8]};
    end else begin
      v24 = {16'd0, dig[8*out_order(4'd15) +: 8]};
    end
    unique case (out_n[1:0])
      2'd0: sextet = v24[5:0];
      2'd1: sextet = v24[11:6];
      2'd2: sextet = v24[17:12];
      default: sextet = v24[23:18];
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_busy <= 1'b0;
      out_n <= '0;
      hash_valid <= 1'b0;
    end else begin
      hash_valid <= out_busy;
      if (cmd.go && cmd.src == SRC_OUT) begin
        out_busy <= 1'b1;
        out_n <= '0;
      end else if (out_busy) begin
        out_n <= out_n + 5'd1;
        if (out_end) out_busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    hash_char <= b64_char(sextet);
    char_last <= (out_n == 5'(HASH_CHARS - 1));
    overflow <= ovf;
  end

  assign stat.seg_done = done;
  assign stat.out_done = out_end;

endmodule

/* rtl/md5_crypt_password_hash.sv */
// Channel  | Handshake             | Payload
// input    | start, busy           | pw_byte, has_byte, pw_last
// config   | cfg_we                | cfg_index, cfg_data
// result   | hash_valid (strobe)   | hash_char, char_last, overflow
// A byte item without pw_last is taken while start is high and busy is low. The
// final item runs the hash: bytes are fed one per cycle while the
// one-step-per-cycle MD5 round unit is not busy with a 64-byte block; a
// strengthening round feeds one or two blocks; then 22 characters follow on
// consecutive cycles. busy stays high from that item until the last character.
// Synchronous reset clears control state; results cannot stall.
module md5_crypt_password_hash
  import md5c_pkg::*;
#(
  parameter int MAX_PASSWORD = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [7:0]  pw_byte,
  input  logic        has_byte,
  input  logic        pw_last,
  input  logic        cfg_we,
  input  logic [0:0]  cfg_index,
  input  logic [63:0] cfg_data,
  output logic [7:0]  hash_char,
  output logic        char_last,
  output logic        overflow,
  output logic        hash_valid
);

  cmd_t  cmd;
  stat_t stat;
  logic  accept;

  assign accept = start && !busy;

  md5c_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .pw_last (pw_last),
    .stat    (stat),
    .busy    (busy),
    .cmd     (cmd)
  );

  md5c_dp #(
    .MAX_PASSWORD (MAX_PASSWORD)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .accept     (accept),
    .pw_byte    (pw_byte),
    .has_byte   (has_byte),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .cmd        (cmd),
    .stat       (stat),
    .hash_char  (hash_char),
    .char_last  (char_last),
    .overflow   (overflow),
    .hash_valid (hash_valid)
  );

endmodule

/* tb/md5_crypt_password_hash_tb.sv */
module md5_crypt_password_hash_tb
  import md5c_pkg::*;
();

  typedef logic [7:0] dig_t [16];

  typedef struct packed {
    logic [7:0] pw_byte;
    logic       has_byte;
    logic       pw_last;
  } pw_item_t;

  typedef struct packed {
    logic [7:0] ch;
    logic       last;
    logic       ovf;
  } hash_out_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic        busy;
  logic [7:0]  pw_byte = '0;
  logic        has_byte = 1'b0;
  logic        pw_last = 1'b0;
  logic        cfg_we = 1'b0;
  logic [0:0]  cfg_index = CFG_SALT_CHARS;
  logic [63:0] cfg_data = '0;
  logic [7:0]  hash_char;
  logic        char_last;
  logic        overflow;
  logic        hash_valid;

  pw_item_t    pending_items[$];
  hash_out_t   hash_expect[$];
  int          n_pushed = 0;
  int          n_taken = 0;
  int          n_errors = 0;
  int          gap = 0;
  int          n_counted;
  pw_item_t    cur;

  logic [63:0] salt_reg = '0;
  logic [3:0]  salt_len_reg = '0;
  logic [7:0]  pw_store[$];
  logic        pw_ovf = 1'b0;

  logic [31:0] ktab [64];
  int          rot_tab [16];
  int          order_tab [16];
  string       alpha = "./0123456789ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz";

  md5_crypt_password_hash DUT (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .pw_byte(pw_byte), .has_byte(has_byte), .pw_last(pw_last),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .hash_char(hash_char), .char_last(char_last), .overflow(overflow),
    .hash_valid(hash_valid)
  );

  always #1 clk = ~clk;

  initial begin
    ktab = '{
      32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee, 32'hf57c0faf, 32'h4787c62a,
      32'ha8304613, 32'hfd469501, 32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
      32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821, 32'hf61e2562, 32'hc040b340,
      32'h265e5a51, 32'he9b6c7aa, 32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
      32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed, 32'ha9e3e905, 32'hfcefa3f8,
      32'h676f02d9, 32'h8d2a4c8a, 32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
      32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70, 32'h289b7ec6, 32'heaa127fa,
      32'hd4ef3085, 32'h04881d05, 32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
      32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039, 32'h655b59c3, 32'h8f0ccc92,
      32'hffeff47d, 32'h85845dd1, 32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
      32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391};
    rot_tab = '{7, 12, 17, 22, 5, 9, 14, 20, 4, 11, 16, 23, 6, 10, 15, 21};
    order_tab = '{0, 6, 12, 1, 7, 13, 2, 8, 14, 3, 9, 15, 4, 10, 5, 11};
  end

  function automatic dig_t md5_bytes(input logic [7:0] m[$]);
    logic [31:0] h [4];
    logic [31:0] w [16];
    logic [31:0] a, b, c, d, f, t;
    logic [63:0] bits;
    int          g, s;
    dig_t        r;
    bits = 64'(m.size()) * 8;
    m.push_back(8'h80);
    while (m.size() % 64 != 56) m.push_back(8'h00);
    for (int i = 0; i < 8; i++) m.push_back(bits[8*i +: 8]);
    h = '{32'h67452301, 32'hefcdab89, 32'h98badcfe, 32'h10325476};
    for (int blk = 0; blk < m.size() / 64; blk++) begin
      for (int i = 0; i < 16; i++)
        w[i] = {m[blk*64 + 4*i + 3], m[blk*64 + 4*i + 2], m[blk*64 + 4*i + 1], m[blk*64 + 4*i]};
      a = h[0]; b = h[1]; c = h[2]; d = h[3];
      for (int i = 0; i < 64; i++) begin
        if (i < 16) begin
          f = (b & c) | (~b & d); g = i;
        end else if (i < 32) begin
          f = (d & b) | (~d & c); g = (5*i + 1) % 16;
        end else if (i < 48) begin
          f = b ^ c ^ d; g = (3*i + 5) % 16;
        end else begin
          f = c ^ (b | ~d); g = (7*i) % 16;
        end
        s = rot_tab[(i / 16) * 4 + (i % 4)];
        t = a + f + ktab[i] + w[g];
        a = d; d = c; c = b;
        b = b + ((t << s) | (t >> (32 - s)));
      end
      h[0] += a; h[1] += b; h[2] += c; h[3] += d;
    end
    for (int i = 0; i < 16; i++) r[i] = h[i/4][8*(i%4) +: 8];
    return r;
  endfunction

  function automatic void hash_password();
    logic [7:0] salt[$];
    logic [7:0] msg[$];
    dig_t       dg;
    int         sl, pl, v, cnt, n;
    sl = (salt_len_reg > 8) ? 8 : int'(salt_len_reg);
    for (int i = 0; i < sl; i++) salt.push_back(salt_reg[8*i +: 8]);
    pl = pw_store.size();
    msg = {pw_store, salt, pw_store};
    dg = md5_bytes(msg);
    msg = {pw_store, 8'h24, 8'h31, 8'h24, salt};
    for (int i = pl; i > 0; i = (i > 16) ? i - 16 : 0)
      for (int j = 0; j < ((i > 16) ? 16 : i); j++) msg.push_back(dg[j]);
    for (int i = pl; i != 0; i = i >> 1)
      msg.push_back((i % 2) ? 8'h00 : pw_store[0]);
    dg = md5_bytes(msg);
    for (int r = 0; r < ROUNDS; r++) begin
      msg = {};
      if (r % 2) msg = {msg, pw_store};
      else for (int j = 0; j < 16; j++) msg.push_back(dg[j]);
      if (r % 3) msg = {msg, salt};
      if (r % 7) msg = {msg, pw_store};
      if (r % 2) for (int j = 0; j < 16; j++) msg.push_back(dg[j]);
      else msg = {msg, pw_store};
      dg = md5_bytes(msg);
    end
    n = 0;
    for (int k = 0; k < 6; k++) begin
      if (k < 5) begin
        v = (int'(dg[order_tab[3*k]]) << 16) | (int'(dg[order_tab[3*k+1]]) << 8)
            | int'(dg[order_tab[3*k+2]]);
        cnt = 4;
      end else begin
        v = dg[order_tab[15]];
        cnt = 2;
      end
      for (int i = 0; i < cnt; i++) begin
        hash_expect.push_back('{alpha[v & 63], n == HASH_CHARS - 1, pw_ovf});
        v = v >> 6;
        n++;
      end
    end
    pw_store = {};
    pw_ovf = 1'b0;
  endfunction

  function automatic void absorb_item(input pw_item_t it);
    if (it.has_byte) begin
      if (pw_store.size() < 32) pw_store.push_back(it.pw_byte);
      else pw_ovf = 1'b1;
    end
    if (it.pw_last) hash_password();
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      start <= 1'b0;
      gap <= 0;
    end else begin
      if (start && !busy) begin
        absorb_item(cur);
        n_taken++;
      end
      if (!start || !busy) begin
        if (gap > 0) begin
          gap <= gap - 1;
          start <= 1'b0;
        end else if (pending_items.size() > 0) begin
          cur = pending_items.pop_front();
          pw_byte <= cur.pw_byte;
          has_byte <= cur.has_byte;
          pw_last <= cur.pw_last;
          start <= 1'b1;
          gap <= $urandom_range(0, 4);
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  task automatic report(input string what, input int got, input int want);
    $display("mismatch %s: got %0h expected %0h", what, got, want);
    n_errors++;
  endtask

  always @(posedge clk) begin
    hash_out_t e;
    if (!rst && hash_valid) begin
      if (hash_expect.size() == 0) begin
        report("unexpected char", hash_char, 0);
      end else begin
        e = hash_expect.pop_front();
        if (hash_char !== e.ch) report("hash_char", hash_char, e.ch);
        if (char_last !== e.last) report("char_last", char_last, e.last);
        if (overflow !== e.ovf) report("overflow", overflow, e.ovf);
      end
    end
  end

  task automatic push_item(input logic [7:0] b, input logic hb, input logic lst);
    pending_items.push_back('{b, hb, lst});
    n_pushed++;
    if (hb || lst) n_counted++;
  endtask

  task automatic wait_idle();
    while (n_taken != n_pushed || hash_expect.size() != 0 || start) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  task automatic write_salt(input logic [63:0] chars, input logic [63:0] len);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= CFG_SALT_CHARS;
    cfg_data <= chars;
    @(posedge clk);
    cfg_index <= CFG_SALT_LENGTH;
    cfg_data <= len;
    @(posedge clk);
    cfg_we <= 1'b0;
    salt_reg = chars;
    salt_len_reg = len[3:0];
  endtask

  task automatic push_password(input int len, input logic tail_byte);
    for (int i = 0; i < len; i++) begin
      if ($urandom_range(0, 7) == 0) push_item(8'($urandom), 1'b0, 1'b0);
      push_item(8'($urandom), 1'b1, 1'b0);
    end
    push_item(8'($urandom), tail_byte, 1'b1);
  endtask

  initial begin
    int len;
    n_counted = 0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    // empty password with salt at reset value
    push_item(8'h00, 1'b0, 1'b1);
    wait_idle();
    write_salt(64'h7473_6c61_7374_6c61, 64'd8);
    push_item(8'h00, 1'b1, 1'b0);
    push_item(8'hff, 1'b1, 1'b0);
    push_item(8'h00, 1'b0, 1'b0);
    push_item(8'h61, 1'b1, 1'b1);
    push_item(8'h41, 1'b1, 1'b1);
    wait_idle();
    // salt length above eight saturates, salt may hold '$'
    write_salt(64'hffff_ffff_ffff_ff24, 64'd15);
    push_item(8'h80, 1'b1, 1'b0);
    push_item(8'h7f, 1'b0, 1'b1);
    wait_idle();
    write_salt(64'h0, 64'd0);
    for (int i = 0; i < 34; i++) push_item(8'(i * 37 + 1), 1'b1, 1'b0);
    push_item(8'h55, 1'b1, 1'b1);
    wait_idle();
    n_counted = 0;
    while (n_counted < 60) begin
      write_salt({$urandom, $urandom}, 64'($urandom_range(0, 15)));
      repeat ($urandom_range(1, 3)) begin
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 35) : $urandom_range(0, 10);
        push_password(len, 1'($urandom_range(0, 1)));
      end
      wait_idle();
    end
    wait_idle();
    if (n_errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  initial begin
    #200000000;
    $display("Test completed with failures");
    $finish;
  end

endmodule
